// File: src/bspc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspc_pkg
// shared types and constants of the billboard sprite projection and cull
// ----------------------------------------------------------------------------
package bspc_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam int DIFF_W  = 33;
  localparam int PROD_W  = 49;
  localparam int DEPTH_W = 36;
  localparam int NUM_W   = 43;
  localparam int QUO_W   = 24;
  localparam int WIDE_W  = 48;

  localparam logic [26:0] FOCAL_RST = 27'd10485760;
  localparam logic [15:0] COS_RST   = 16'd16384;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPRITE = 3'd1,
    ST_TOO_NEAR  = 3'd2,
    ST_OFF_H     = 3'd3,
    ST_OFF_V     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_CAM_X = 3'd0,
    REG_CAM_Y = 3'd1,
    REG_CAM_Z = 3'd2,
    REG_COS   = 3'd3,
    REG_SIN   = 3'd4,
    REG_FOCAL = 3'd5
  } reg_idx_e;

  typedef struct packed {
    status_e                     status;
    logic signed [DEPTH_W-1:0]   depth;
    logic signed [DEPTH_W-1:0]   offs;
    logic signed [DIFF_W-1:0]    dz;
    logic [9:0]                  wid;
    logic [9:0]                  hgt;
    logic signed [10:0]          topoff;
    logic                        mip;
    logic [8:0]                  shade;
  } pld_t;

endpackage

// File: src/bspc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspc_div
// pipelined restoring divider, one quotient bit per stage, payload alongside
// ----------------------------------------------------------------------------
module bspc_div
  import bspc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [NUM_W-1:0]   numer_i,
  input  logic [DEPTH_W-1:0] denom_i,
  input  pld_t               pld_i,
  output logic               valid_o,
  output logic [QUO_W-1:0]   quo_o,
  output pld_t               pld_o
);

  localparam int HI_W = NUM_W - QUO_W;

  logic               src_v   [QUO_W+1];
  logic [DEPTH_W-1:0] src_rem [QUO_W+1];
  logic [DEPTH_W-1:0] src_den [QUO_W+1];
  logic [QUO_W-1:0]   src_nlo [QUO_W+1];
  logic [QUO_W-1:0]   src_quo [QUO_W+1];
  pld_t               src_pld [QUO_W+1];

  assign src_v[0]   = valid_i;
  assign src_rem[0] = {{(DEPTH_W-HI_W){1'b0}}, numer_i[NUM_W-1:QUO_W]};
  assign src_den[0] = denom_i;
  assign src_nlo[0] = numer_i[QUO_W-1:0];
  assign src_quo[0] = '0;
  assign src_pld[0] = pld_i;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEPTH_W:0]   rem_sh;
    logic [DEPTH_W:0]   diff;
    logic               ge;
    logic               v_q;
    logic [DEPTH_W-1:0] rem_q;
    logic [DEPTH_W-1:0] den_q;
    logic [QUO_W-1:0]   nlo_q;
    logic [QUO_W-1:0]   quo_q;
    pld_t               pld_q;

    assign rem_sh = {src_rem[k], src_nlo[k][QUO_W-1]};
    assign diff   = rem_sh - {1'b0, src_den[k]};
    assign ge     = rem_sh >= {1'b0, src_den[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= src_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= ge ? diff[DEPTH_W-1:0] : rem_sh[DEPTH_W-1:0];
        den_q <= src_den[k];
        nlo_q <= {src_nlo[k][QUO_W-2:0], 1'b0};
        quo_q <= {src_quo[k][QUO_W-2:0], ge};
        pld_q <= src_pld[k];
      end
    end

    assign src_v[k+1]   = v_q;
    assign src_rem[k+1] = rem_q;
    assign src_den[k+1] = den_q;
    assign src_nlo[k+1] = nlo_q;
    assign src_quo[k+1] = quo_q;
    assign src_pld[k+1] = pld_q;
  end

  assign valid_o = src_v[QUO_W];
  assign quo_o   = src_quo[QUO_W];
  assign pld_o   = src_pld[QUO_W];

endmodule

// File: src/billboard_sprite_project_cull.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// billboard_sprite_project_cull
// projects one object word per cycle when not stalled, using the configured camera, and culls
// ----------------------------------------------------------------------------
// One object word is taken every cycle unless the output side stalls. Each
// word passes three stages for the camera offset, rotation and depth, 24 stages
// of the divider that forms scale one quotient bit per stage, and four stages
// of scaling, screen placement, culling and the output register. A stall at
// the output freezes the whole pipeline; in_ready_o is out_ready_i || !out_valid_o.
// ----------------------------------------------------------------------------
module billboard_sprite_project_cull
  import bspc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  thing_x_i,
  input  logic signed [31:0]  thing_y_i,
  input  logic signed [31:0]  thing_z_i,
  input  logic                has_sprite_i,
  input  logic [9:0]          sprite_width_i,
  input  logic [9:0]          sprite_height_i,
  input  logic signed [10:0]  top_offset_i,
  input  logic                has_mip_i,
  input  logic [8:0]          shade_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [30:0]         depth_out_o,
  output logic signed [31:0]  screen_x_o,
  output logic signed [31:0]  screen_y_o,
  output logic [30:0]         scale_out_o,
  output logic                use_mip_o,
  output logic [8:0]          shade_out_o
);

  localparam logic signed [WIDE_W-1:0] SX0    = WIDE_W'(SCREEN_WIDTH) <<< 15;
  localparam logic signed [WIDE_W-1:0] SY0    = WIDE_W'(SCREEN_HEIGHT) <<< 15;
  localparam logic signed [WIDE_W-1:0] XMAX   = WIDE_W'(SCREEN_WIDTH) <<< 16;
  localparam logic signed [WIDE_W-1:0] MARGIN = WIDE_W'(2) <<< 16;
  localparam logic signed [WIDE_W-1:0] YMAX   = (WIDE_W'(SCREEN_HEIGHT) <<< 16) + MARGIN;
  localparam logic signed [WIDE_W-1:0] I32MAX = WIDE_W'(32'h7fff_ffff);
  localparam logic signed [WIDE_W-1:0] I32MIN = -(WIDE_W'(1) <<< 31);
  localparam logic signed [DEPTH_W-1:0] NEAR  = DEPTH_W'(1) <<< 19;

  // configuration
  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
  logic signed [15:0] view_cos_q, view_sin_q;
  logic [26:0]        focal_q;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q    <= '0;
      cam_y_q    <= '0;
      cam_z_q    <= '0;
      view_cos_q <= COS_RST;
      view_sin_q <= '0;
      focal_q    <= FOCAL_RST;
    end else if (wr_en) begin
      unique case (reg_idx_e'(paddr[PADDR_W-1:2]))
        REG_CAM_X: cam_x_q    <= pwdata;
        REG_CAM_Y: cam_y_q    <= pwdata;
        REG_CAM_Z: cam_z_q    <= pwdata;
        REG_COS:   view_cos_q <= pwdata[15:0];
        REG_SIN:   view_sin_q <= pwdata[15:0];
        REG_FOCAL: focal_q    <= pwdata[26:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[PADDR_W-1:2]))
      REG_CAM_X: prdata = cam_x_q;
      REG_CAM_Y: prdata = cam_y_q;
      REG_CAM_Z: prdata = cam_z_q;
      REG_COS:   prdata = {16'b0, view_cos_q};
      REG_SIN:   prdata = {16'b0, view_sin_q};
      REG_FOCAL: prdata = {5'b0, focal_q};
      default:   prdata = '0;
    endcase
  end

  // pipeline advance
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 1: offset from camera
  logic                     s1_v_q, s1_spr_q;
  logic signed [DIFF_W-1:0] s1_dx_q, s1_dy_q, s1_dz_q;
  logic [9:0]               s1_wid_q, s1_hgt_q;
  logic signed [10:0]       s1_top_q;
  logic                     s1_mip_q;
  logic [8:0]               s1_shade_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dx_q    <= DIFF_W'(thing_x_i) - DIFF_W'(cam_x_q);
      s1_dy_q    <= DIFF_W'(thing_y_i) - DIFF_W'(cam_y_q);
      s1_dz_q    <= DIFF_W'(thing_z_i) - DIFF_W'(cam_z_q);
      s1_spr_q   <= has_sprite_i;
      s1_wid_q   <= sprite_width_i;
      s1_hgt_q   <= sprite_height_i;
      s1_top_q   <= top_offset_i;
      s1_mip_q   <= has_mip_i;
      s1_shade_q <= shade_in_i;
    end
  end

  // stage 2: rotation products
  logic                     s2_v_q, s2_spr_q;
  logic signed [PROD_W-1:0] s2_p1_q, s2_p2_q, s2_p3_q, s2_p4_q;
  logic signed [DIFF_W-1:0] s2_dz_q;
  logic [9:0]               s2_wid_q, s2_hgt_q;
  logic signed [10:0]       s2_top_q;
  logic                     s2_mip_q;
  logic [8:0]               s2_shade_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_p1_q    <= s1_dx_q * view_cos_q;
      s2_p2_q    <= s1_dy_q * view_sin_q;
      s2_p3_q    <= s1_dx_q * view_sin_q;
      s2_p4_q    <= s1_dy_q * view_cos_q;
      s2_dz_q    <= s1_dz_q;
      s2_spr_q   <= s1_spr_q;
      s2_wid_q   <= s1_wid_q;
      s2_hgt_q   <= s1_hgt_q;
      s2_top_q   <= s1_top_q;
      s2_mip_q   <= s1_mip_q;
      s2_shade_q <= s1_shade_q;
    end
  end

  // stage 3: depth, sideways offset and near cull
  logic signed [PROD_W:0]    sum_d, dif_d;
  logic signed [DEPTH_W-1:0] depth_d;
  logic                      s3_v_q;
  pld_t                      s3_pld_q;
  pld_t                      s3_pld_d;

  always_comb begin
    sum_d   = (PROD_W+1)'(s2_p1_q) + (PROD_W+1)'(s2_p2_q);
    dif_d   = (PROD_W+1)'(s2_p3_q) - (PROD_W+1)'(s2_p4_q);
    depth_d = sum_d[PROD_W:14];
    s3_pld_d.depth  = depth_d;
    s3_pld_d.offs   = dif_d[PROD_W:14];
    s3_pld_d.dz     = s2_dz_q;
    s3_pld_d.wid    = s2_wid_q;
    s3_pld_d.hgt    = s2_hgt_q;
    s3_pld_d.topoff = s2_top_q;
    s3_pld_d.mip    = s2_mip_q;
    s3_pld_d.shade  = s2_shade_q;
    priority if (!s2_spr_q) begin
      s3_pld_d.status = ST_NO_SPRITE;
    end else if (depth_d < NEAR) begin
      s3_pld_d.status = ST_TOO_NEAR;
    end else begin
      s3_pld_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_pld_q <= s3_pld_d;
    end
  end

  // scale = focal * 2^16 / depth
  logic             dv_v;
  logic [QUO_W-1:0] dv_quo;
  pld_t             dv_pld;

  bspc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .numer_i ({focal_q, 16'b0}),
    .denom_i (s3_pld_q.depth),
    .pld_i   (s3_pld_q),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .pld_o   (dv_pld)
  );

  // stage 4: scaled terms
  logic                      s4_v_q;
  pld_t                      s4_pld_q;
  logic [QUO_W-1:0]          s4_scale_q;
  logic signed [DEPTH_W+QUO_W:0] s4_moffs_q;
  logic signed [DIFF_W+QUO_W:0]  s4_mdz_q;
  logic [QUO_W+9:0]          s4_halfw_q, s4_hs_q;
  logic signed [QUO_W+11:0]  s4_tos_q;
  logic signed [QUO_W:0]     scl_s;

  assign scl_s = {1'b0, dv_quo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_pld_q   <= dv_pld;
      s4_scale_q <= dv_quo;
      s4_moffs_q <= dv_pld.offs * scl_s;
      s4_mdz_q   <= dv_pld.dz * scl_s;
      s4_halfw_q <= dv_pld.wid * dv_quo;
      s4_hs_q    <= dv_pld.hgt * dv_quo;
      s4_tos_q   <= dv_pld.topoff * scl_s;
    end
  end

  // stage 5: screen anchor
  logic                     s5_v_q;
  pld_t                     s5_pld_q;
  logic [QUO_W-1:0]         s5_scale_q;
  logic signed [WIDE_W-1:0] s5_sx_q, s5_sy_q, s5_halfw_q, s5_hs_q, s5_tos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_pld_q   <= s4_pld_q;
      s5_scale_q <= s4_scale_q;
      s5_sx_q    <= SX0 + WIDE_W'(s4_moffs_q >>> 16);
      s5_sy_q    <= SY0 - WIDE_W'(s4_mdz_q >>> 16);
      s5_halfw_q <= $signed(WIDE_W'(s4_halfw_q));
      s5_hs_q    <= $signed(WIDE_W'(s4_hs_q));
      s5_tos_q   <= WIDE_W'(s4_tos_q);
    end
  end

  // stage 6: horizontal cull and sprite top
  logic                     s6_v_q, s6_offh_q;
  pld_t                     s6_pld_q;
  logic [QUO_W-1:0]         s6_scale_q;
  logic signed [WIDE_W-1:0] s6_sx_q, s6_sy_q, s6_top_q, s6_bot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (en) begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_pld_q   <= s5_pld_q;
      s6_scale_q <= s5_scale_q;
      s6_sx_q    <= s5_sx_q;
      s6_sy_q    <= s5_sy_q;
      s6_offh_q  <= (s5_sx_q + s5_halfw_q < 0) || (s5_sx_q - s5_halfw_q > XMAX);
      s6_top_q   <= s5_sy_q - s5_tos_q;
      s6_bot_q   <= s5_sy_q - s5_tos_q + s5_hs_q;
    end
  end

  // stage 7: vertical cull, status and output word
  status_e     st_d;
  logic        ok_d;
  logic [30:0] depth_d7;
  logic [31:0] sx_d, sy_d;

  always_comb begin
    priority if (s6_pld_q.status != ST_OK) begin
      st_d = s6_pld_q.status;
    end else if (s6_offh_q) begin
      st_d = ST_OFF_H;
    end else if (s6_top_q > YMAX || s6_bot_q < -MARGIN) begin
      st_d = ST_OFF_V;
    end else begin
      st_d = ST_OK;
    end
    ok_d     = st_d == ST_OK;
    depth_d7 = (s6_pld_q.depth[DEPTH_W-1:31] != '0) ? 31'h7fff_ffff
                                                    : s6_pld_q.depth[30:0];
    priority if (s6_sx_q > I32MAX) begin
      sx_d = I32MAX[31:0];
    end else if (s6_sx_q < I32MIN) begin
      sx_d = I32MIN[31:0];
    end else begin
      sx_d = s6_sx_q[31:0];
    end
    priority if (s6_sy_q > I32MAX) begin
      sy_d = I32MAX[31:0];
    end else if (s6_sy_q < I32MIN) begin
      sy_d = I32MIN[31:0];
    end else begin
      sy_d = s6_sy_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_o    <= st_d;
      depth_out_o <= ok_d ? depth_d7 : '0;
      screen_x_o  <= ok_d ? sx_d : '0;
      screen_y_o  <= ok_d ? sy_d : '0;
      scale_out_o <= ok_d ? 31'(s6_scale_q) : '0;
      use_mip_o   <= ok_d && s6_pld_q.mip && (s6_scale_q < QUO_W'(32768));
      shade_out_o <= ok_d ? s6_pld_q.shade : '0;
    end
  end

endmodule

// File: src/bspc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspc_chk
// port level checks of the billboard sprite projection and cull
// ----------------------------------------------------------------------------
module bspc_chk
  import bspc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [30:0] depth_out_o,
  input logic [30:0] scale_out_o,
  input logic        use_mip_o,
  input logic [8:0]  shade_out_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("output word dropped while stalled");

  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      depth_out_o == '0 && scale_out_o == '0 && !use_mip_o && shade_out_o == '0)
    else $error("rejected word carries data");

  a_mip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && use_mip_o |-> status_o == ST_OK && scale_out_o < 31'd32768)
    else $error("mip chosen at large scale");

  a_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> depth_out_o >= 31'd524288)
    else $error("accepted word nearer than clip depth");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_OFF_V)
    else $error("status code out of range");

endmodule

bind billboard_sprite_project_cull bspc_chk u_bspc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .depth_out_o (depth_out_o),
  .scale_out_o (scale_out_o),
  .use_mip_o   (use_mip_o),
  .shade_out_o (shade_out_o)
);

// File: verif/billboard_sprite_project_cull_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// billboard_sprite_project_cull_tb
// self-checking bench for the billboard sprite projection and cull block
// ----------------------------------------------------------------------------
// Drives object words through the valid/ready input while the output side
// stalls at random. Each accepted word is projected by a local integer model
// of the camera, and the resulting status, depth, screen anchor, scale, mip
// choice and shade are queued. The result words are then checked in order.
// Camera registers are rewritten over the APB port between phases. The
// camera setups include the reset values, the extremes and random angles.
// ----------------------------------------------------------------------------
module billboard_sprite_project_cull_tb;
  import bspc_pkg::*;

  localparam longint NEAR_Q16   = 64'sd8 << 16;
  localparam longint HALF_Q16   = 64'sd1 << 15;
  localparam longint MARGIN_Q16 = 64'sd2 << 16;
  localparam longint MAX31      = 64'sd2147483647;
  localparam longint MAX32      = 64'sd2147483647;
  localparam longint MIN32      = -64'sd2147483648;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     DRAIN_CYCLES = 40;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               spr;
    logic [9:0]         w;
    logic [9:0]         h;
    logic signed [10:0] top;
    logic               mip;
    logic [8:0]         shade;
  } thing_t;

  typedef struct {
    status_e     status;
    logic [30:0] depth;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [30:0] scale;
    logic        mip;
    logic [8:0]  shade;
  } sprite_res_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i, in_ready_o;
  logic signed [31:0] thing_x_i, thing_y_i, thing_z_i;
  logic               has_sprite_i, has_mip_i;
  logic [9:0]         sprite_width_i, sprite_height_i;
  logic signed [10:0] top_offset_i;
  logic [8:0]         shade_in_i;
  logic               out_valid_o, out_ready_i;
  logic [2:0]         status_o;
  logic [30:0]        depth_out_o, scale_out_o;
  logic signed [31:0] screen_x_o, screen_y_o;
  logic               use_mip_o;
  logic [8:0]         shade_out_o;

  int          cam_x, cam_y, cam_z;
  shortint     view_cos, view_sin;
  logic [26:0] focal;

  sprite_res_t expected_q[$];
  int          mismatches;
  int          cycles;
  int          words_sent;
  int          words_checked;
  int          status_seen[5];
  bit          calm_mode;
  bit          hold_req;
  int          hold_cnt;

  billboard_sprite_project_cull u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .thing_x_i, .thing_y_i, .thing_z_i, .has_sprite_i,
    .sprite_width_i, .sprite_height_i, .top_offset_i, .has_mip_i, .shade_in_i,
    .out_valid_o, .out_ready_i, .status_o, .depth_out_o, .screen_x_o, .screen_y_o,
    .scale_out_o, .use_mip_o, .shade_out_o
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, expected_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic sprite_res_t project_thing(thing_t t);
    sprite_res_t r;
    longint dx, dy, dz, cs, sn, dep, offs, scl, sx, sy, hw, top;
    r = '{status: ST_OK, default: '0};
    if (!t.spr) begin
      r.status = ST_NO_SPRITE;
      return r;
    end
    cs  = longint'(view_cos);
    sn  = longint'(view_sin);
    dx  = longint'(t.x) - longint'(cam_x);
    dy  = longint'(t.y) - longint'(cam_y);
    dz  = longint'(t.z) - longint'(cam_z);
    dep = (dx * cs + dy * sn) >>> 14;
    if (dep < NEAR_Q16) begin
      r.status = ST_TOO_NEAR;
      return r;
    end
    offs = (dx * sn - dy * cs) >>> 14;
    scl  = clamp((longint'(focal) << 16) / dep, 0, MAX31);
    sx   = longint'(SCREEN_WIDTH) * HALF_Q16 + ((offs * scl) >>> 16);
    hw   = longint'(t.w) * scl;
    if (sx + hw < 0 || sx - hw > (longint'(SCREEN_WIDTH) << 16)) begin
      r.status = ST_OFF_H;
      return r;
    end
    sy  = longint'(SCREEN_HEIGHT) * HALF_Q16 - ((dz * scl) >>> 16);
    top = sy - longint'(t.top) * scl;
    if (top > (longint'(SCREEN_HEIGHT) << 16) + MARGIN_Q16 ||
        top + longint'(t.h) * scl < -MARGIN_Q16) begin
      r.status = ST_OFF_V;
      return r;
    end
    r.depth = 31'(clamp(dep, 0, MAX31));
    r.sx    = 32'(clamp(sx, MIN32, MAX32));
    r.sy    = 32'(clamp(sy, MIN32, MAX32));
    r.scale = 31'(scl);
    r.mip   = t.mip && (scl < HALF_Q16);
    r.shade = t.shade;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    sprite_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", status_o, 0);
      end else begin
        e = expected_q.pop_front();
        words_checked++;
        status_seen[e.status]++;
        if (status_o !== e.status) report_mismatch("status", status_o, e.status);
        if (depth_out_o !== e.depth) report_mismatch("depth", depth_out_o, e.depth);
        if (screen_x_o !== e.sx) report_mismatch("screen_x", screen_x_o, e.sx);
        if (screen_y_o !== e.sy) report_mismatch("screen_y", screen_y_o, e.sy);
        if (scale_out_o !== e.scale) report_mismatch("scale", scale_out_o, e.scale);
        if (use_mip_o !== e.mip) report_mismatch("use_mip", use_mip_o, e.mip);
        if (shade_out_o !== e.shade) report_mismatch("shade", shade_out_o, e.shade);
      end
    end
  end

  // output side stalls, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt    <= 250;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_ready_i <= (hold_cnt == 1);
    end else if (calm_mode) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 30);
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CAM_X: cam_x = val;
      REG_CAM_Y: cam_y = val;
      REG_CAM_Z: cam_z = val;
      REG_COS:   view_cos = val[15:0];
      REG_SIN:   view_sin = val[15:0];
      REG_FOCAL: focal = val[26:0];
      default: ;
    endcase
  endtask

  task automatic set_camera(int cx, int cy, int cz, int cs, int sn, int fl);
    write_reg(REG_CAM_X, cx);
    write_reg(REG_CAM_Y, cy);
    write_reg(REG_CAM_Z, cz);
    write_reg(REG_COS, cs);
    write_reg(REG_SIN, sn);
    write_reg(REG_FOCAL, fl);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_thing(thing_t t);
    if (!calm_mode && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    thing_x_i       <= t.x;
    thing_y_i       <= t.y;
    thing_z_i       <= t.z;
    has_sprite_i    <= t.spr;
    sprite_width_i  <= t.w;
    sprite_height_i <= t.h;
    top_offset_i    <= t.top;
    has_mip_i       <= t.mip;
    shade_in_i      <= t.shade;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(project_thing(t));
    words_sent++;
    @(negedge clk_i);
  endtask

  function automatic thing_t mk(longint x, longint y, longint z, int w, int h, int top);
    thing_t t;
    t.x = 32'(x);
    t.y = 32'(y);
    t.z = 32'(z);
    t.spr = 1'b1;
    t.w = 10'(w);
    t.h = 10'(h);
    t.top = 11'(top);
    t.mip = 1'b1;
    t.shade = 9'd256;
    return t;
  endfunction

  function automatic thing_t noise_thing();
    thing_t t;
    t.x = $urandom;
    t.y = $urandom;
    t.z = $urandom;
    t.spr = 1'($urandom_range(1));
    t.w = 10'($urandom);
    t.h = 10'($urandom);
    t.top = 11'($urandom);
    t.mip = 1'($urandom_range(1));
    t.shade = 9'($urandom);
    return t;
  endfunction

  // object placed in front of the camera at a chosen depth and side offset
  function automatic thing_t framed_thing();
    thing_t t;
    longint d, o, dz;
    d  = longint'($urandom_range(32'h0008_0000, 32'h03E8_0000));
    if ($urandom_range(9) == 0) d = NEAR_Q16 - 4 + $urandom_range(8);
    o  = longint'($urandom_range(0, 32'(d))) - d / 2;
    dz = longint'($urandom_range(0, 32'(d / 2))) - d / 4;
    t = noise_thing();
    t.spr = ($urandom_range(19) != 0);
    t.w = 10'($urandom_range(0, 64));
    t.h = 10'($urandom_range(0, 128));
    t.top = 11'(int'($urandom_range(0, 160)) - 16);
    t.shade = 9'($urandom_range(0, 256));
    t.x = 32'(longint'(cam_x) + ((d * view_cos + o * view_sin) >>> 14));
    t.y = 32'(longint'(cam_y) + ((d * view_sin - o * view_cos) >>> 14));
    t.z = 32'(longint'(cam_z) + dz);
    return t;
  endfunction

  task automatic test_directed();
    thing_t t;
    t = mk(8 << 16, 0, 0, 10, 10, 0);
    t.spr = 1'b0;
    send_thing(t);
    send_thing(mk((8 << 16) - 1, 0, 0, 10, 10, 0));
    send_thing(mk(8 << 16, 0, 0, 10, 10, 0));
    send_thing(mk(8 << 16, 0, 0, 0, 0, 0));
    send_thing(mk(20 << 16, 300 << 16, 0, 4, 10, 0));
    send_thing(mk(20 << 16, -(300 << 16), 0, 4, 10, 0));
    send_thing(mk(20 << 16, 0, 200 << 16, 10, 10, 0));
    send_thing(mk(20 << 16, 0, -(200 << 16), 10, 10, 0));
    send_thing(mk(400 << 16, 0, 0, 10, 10, 5));
    t = mk(400 << 16, 0, 0, 10, 10, 5);
    t.mip = 1'b0;
    send_thing(t);
    send_thing(mk(32'h7FFF_FFFF, 0, 0, 1023, 1023, -1024));
    send_thing(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1023, 1023, 1023));
    send_thing(mk(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 0, 0, 0));
    t = mk(50 << 16, 3 << 16, 1 << 16, 1023, 1023, 1023);
    t.shade = 9'h1FF;
    send_thing(t);
    t = mk(50 << 16, -(3 << 16), -(1 << 16), 0, 1023, -1024);
    t.shade = 9'd0;
    send_thing(t);
    send_thing(mk(8 << 16, 0, (120 << 16) / 20 + (1 << 16), 0, 0, 0));
  endtask

  task automatic test_config_extremes();
    wait_idle();
    set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h7FFF, 27'h7FF_FFFF);
    repeat (10) send_thing(noise_thing());
    wait_idle();
    set_camera(0, 0, 0, -16384, 16384, 0);
    repeat (10) send_thing(framed_thing());
    wait_idle();
    set_camera(0, 0, 0, 0, -16384, 32'h0400_0000);
    repeat (10) send_thing(framed_thing());
  endtask

  task automatic test_random_sweep(int phases, int per_phase);
    int cs, sn;
    for (int p = 0; p < phases; p++) begin
      wait_idle();
      case ($urandom_range(5))
        0: begin cs = 16384; sn = 0; end
        1: begin cs = 0; sn = 16384; end
        2: begin cs = -11585; sn = 11585; end
        3: begin cs = 11585; sn = -11585; end
        4: begin cs = -16384; sn = 0; end
        default: begin cs = int'($urandom_range(32768)) - 16384; sn = $urandom_range(16384); end
      endcase
      set_camera($urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000,
                 $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000,
                 $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                 cs, sn, $urandom_range(1 << 16, 32'h0400_0000));
      calm_mode = (p == 2);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(99) < 80) send_thing(framed_thing());
        else send_thing(noise_thing());
      end
      calm_mode = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    set_camera(0, 0, 0, 16384, 0, int'(FOCAL_RST));
    hold_req = 1'b1;
    wait (hold_cnt != 0);
    hold_req = 1'b0;
    repeat (120) send_thing(framed_thing());
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    thing_x_i = '0;
    thing_y_i = '0;
    thing_z_i = '0;
    has_sprite_i = 1'b0;
    sprite_width_i = '0;
    sprite_height_i = '0;
    top_offset_i = '0;
    has_mip_i = 1'b0;
    shade_in_i = '0;
    calm_mode = 1'b0;
    hold_req = 1'b0;
    cam_x = 0;
    cam_y = 0;
    cam_z = 0;
    view_cos = COS_RST;
    view_sin = 0;
    focal = FOCAL_RST;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_config_extremes();
    test_random_sweep(12, 100);
    test_backpressure();

    wait_idle();
    $display("%0d object words sent, %0d checked over 16 camera settings", words_sent,
             words_checked);
    $display("status counts: ok %0d, no sprite %0d, too near %0d, off h %0d, off v %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
src/bspc_pkg.sv
src/bspc_div.sv
src/billboard_sprite_project_cull.sv
src/bspc_chk.sv
verif/billboard_sprite_project_cull_tb.sv
